[hdl/tftp_read_client_fsm_defines.svh]
// Assertion macros shared by the checker of the TFTP read client.
`ifndef TFTP_READ_CLIENT_FSM_DEFINES_SVH
`define TFTP_READ_CLIENT_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trc check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trc check failed");

`endif

[hdl/trc_pkg.sv]
// Types and constants of the TFTP read client.
package trc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_SEND = 3'b010,
		PH_WAIT = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_SENT    = 2'd1,
		CMD_PACKET  = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_t;

	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_RRQ  = 2'd1;
	localparam logic [1:0] REQ_ACK  = 2'd2;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam logic [0:0] CFG_MAX_TRIES = 1'b0;
	localparam logic [0:0] CFG_XFER_SIZE = 1'b1;

	localparam logic [15:0] OP_DATA     = 16'd3;
	localparam logic [15:0] HDR_LEN     = 16'd4;
	localparam logic [3:0]  RESET_TRIES = 4'd5;
	localparam logic [15:0] RESET_XFER  = 16'd512;
	localparam logic [3:0]  TRY_MAX     = 4'd15;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 40;

	// Output tdata field positions, used by the checker as well.
	localparam int O_REQ_LO  = 0;
	localparam int O_ACK_LO  = 2;
	localparam int O_DLV     = 18;
	localparam int O_PLEN_LO = 19;
	localparam int O_LATCH   = 35;
	localparam int O_STAT_LO = 36;

	typedef struct packed {
		cmd_t        command;
		logic        send_ok;
		logic [15:0] source_port;
		logic [15:0] packet_length;
		logic [15:0] packet_opcode;
		logic [15:0] packet_block;
		logic        sink_ok;
	} item_t;

	typedef struct packed {
		logic [1:0]  send_request;
		logic [15:0] ack_block;
		logic        deliver_payload;
		logic [15:0] payload_length;
		logic        latch_port;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] block_count;
		logic        end_of_file;
		logic [3:0]  try_count;
		logic [15:0] peer_port;
	} state_t;

	typedef struct packed {
		logic [3:0]  max_tries;
		logic [15:0] transfer_size;
	} cfg_t;

endpackage

[hdl/tftp_read_client_fsm.sv]
// Receiving side of a TFTP read transfer: an event stream in, one result per event out.
// Each request on the slave stream is one event (start, send finished, packet received,
// receive timeout, selected by s_tuser) and gives exactly one result request on the
// master stream: which packet to send next, whether to hand the payload to the sink,
// whether to latch the server port, and the final status when the transfer stops.
// Events are taken at one per clock cycle while the master side does not stall; a result
// is presented on the master side once its event has passed the input register and the
// result register in turn, and is held there while m_tready is low. The transition
// logic sits between those two registers and updates the transfer state as the event
// moves on, so the next event sees the new state without a bubble. A stalled result
// holds the master side while one more event may wait in the input register.
// Configuration (max_tries, transfer_size) is written through cfg_we/cfg_index/cfg_wdata
// and takes effect at once.
module tftp_read_client_fsm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fields from bit 0: send_ok, source_port, packet_length, packet_opcode,
	// packet_block, sink_ok, zero fill
	input  logic [trc_pkg::IN_DATA_W-1:0]  s_tdata,
	// fields from bit 0: command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// fields from bit 0: send_request, ack_block, deliver_payload, payload_length,
	// latch_port, status, zero fill
	output logic [trc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic             valid_s1;
	trc_pkg::item_t   item_s1;
	logic             valid_s2;
	trc_pkg::result_t res_s2;
	trc_pkg::state_t  state_q;
	trc_pkg::state_t  state_nx;
	trc_pkg::result_t res_nx;
	trc_pkg::cfg_t    cfg_q;
	logic             take_s2;
	logic             adv_s1;

	// result register is free when empty or being drained this cycle
	assign take_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && take_s2;
	assign s_tready = !valid_s1 || take_s2;

	// input register: capture an event whenever the slot is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command       <= trc_pkg::cmd_t'(s_tuser);
			item_s1.send_ok       <= s_tdata[0];
			item_s1.source_port   <= s_tdata[16:1];
			item_s1.packet_length <= s_tdata[32:17];
			item_s1.packet_opcode <= s_tdata[48:33];
			item_s1.packet_block  <= s_tdata[64:49];
			item_s1.sink_ok       <= s_tdata[65];
		end
	end

	trc_step u_step (
		.state    (state_q),
		.cfg      (cfg_q),
		.item     (item_s1),
		.state_nx (state_nx),
		.res      (res_nx)
	);

	// transfer state: advance only when the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= trc_pkg::PH_IDLE;
			state_q.block_count <= '0;
			state_q.end_of_file <= 1'b0;
			state_q.try_count   <= '0;
			state_q.peer_port   <= '0;
		end else if (adv_s1) begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_tries     <= trc_pkg::RESET_TRIES;
			cfg_q.transfer_size <= trc_pkg::RESET_XFER;
		end else if (cfg_we) begin
			case (cfg_index)
				trc_pkg::CFG_MAX_TRIES: cfg_q.max_tries     <= cfg_wdata[3:0];
				trc_pkg::CFG_XFER_SIZE: cfg_q.transfer_size <= cfg_wdata;
				default:                cfg_q               <= cfg_q;
			endcase
		end
	end

	// result register: hold while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.status, res_s2.latch_port, res_s2.payload_length,
	                   res_s2.deliver_payload, res_s2.ack_block, res_s2.send_request};

endmodule

[hdl/trc_step.sv]
// Transition logic: one event against the current state gives next state and result.
module trc_step (
	input  trc_pkg::state_t  state,
	input  trc_pkg::cfg_t    cfg,
	input  trc_pkg::item_t   item,
	output trc_pkg::state_t  state_nx,
	output trc_pkg::result_t res
);

	logic        accept;
	logic [16:0] expect_blk;
	logic [15:0] paylen;

	assign expect_blk = {1'b0, state.block_count} + 17'd1;
	assign paylen     = item.packet_length - trc_pkg::HDR_LEN;

	always_comb begin
		state_nx = state;
		res      = '0;
		accept   = 1'b0;
		case (item.command)
			trc_pkg::CMD_START: begin
				state_nx.block_count = '0;
				state_nx.end_of_file = 1'b0;
				state_nx.try_count   = '0;
				state_nx.phase       = trc_pkg::PH_SEND;
				res.send_request     = trc_pkg::REQ_RRQ;
			end
			trc_pkg::CMD_SENT: begin
				if (state.phase == trc_pkg::PH_SEND) begin
					if (item.send_ok && !state.end_of_file) begin
						state_nx.phase = trc_pkg::PH_WAIT;
						if (state.try_count < trc_pkg::TRY_MAX) begin
							state_nx.try_count = state.try_count + 4'd1;
						end
					end else begin
						state_nx.phase = trc_pkg::PH_IDLE;
						res.status = state.end_of_file ? trc_pkg::ST_OK : trc_pkg::ST_FAIL;
					end
				end
			end
			trc_pkg::CMD_PACKET: begin
				if (state.phase == trc_pkg::PH_WAIT) begin
					// first reply fixes the server port
					if (state.block_count == '0) begin
						state_nx.peer_port = item.source_port;
						res.latch_port     = 1'b1;
						accept             = 1'b1;
					end else if (state.peer_port == item.source_port) begin
						accept = 1'b1;
					end
					if (accept) begin
						if (item.packet_length < trc_pkg::HDR_LEN) begin
							state_nx.phase   = trc_pkg::PH_SEND;
							res.send_request = trc_pkg::REQ_RRQ;
						end else begin
							state_nx.try_count = '0;
							if (item.packet_opcode != trc_pkg::OP_DATA) begin
								state_nx.phase = trc_pkg::PH_IDLE;
								res.status = state.end_of_file ? trc_pkg::ST_OK
								                               : trc_pkg::ST_FAIL;
							end else if (expect_blk == {1'b0, item.packet_block}) begin
								state_nx.block_count = item.packet_block;
								res.deliver_payload  = 1'b1;
								res.payload_length   = paylen;
								if (paylen < cfg.transfer_size) begin
									state_nx.end_of_file = 1'b1;
								end
								if (item.sink_ok) begin
									state_nx.phase   = trc_pkg::PH_SEND;
									res.send_request = trc_pkg::REQ_ACK;
									res.ack_block    = item.packet_block;
								end else begin
									// a short block marks end of file even here
									state_nx.phase = trc_pkg::PH_IDLE;
									res.status = (state.end_of_file
										|| paylen < cfg.transfer_size)
										? trc_pkg::ST_OK : trc_pkg::ST_FAIL;
								end
							end
						end
					end
				end
			end
			trc_pkg::CMD_TIMEOUT: begin
				if (state.phase == trc_pkg::PH_WAIT) begin
					if (state.try_count < cfg.max_tries) begin
						state_nx.phase = trc_pkg::PH_SEND;
						if (state.block_count == '0) begin
							res.send_request = trc_pkg::REQ_RRQ;
						end else begin
							res.send_request = trc_pkg::REQ_ACK;
							res.ack_block    = state.block_count;
						end
					end else begin
						state_nx.phase = trc_pkg::PH_IDLE;
						res.status = state.end_of_file ? trc_pkg::ST_OK : trc_pkg::ST_FAIL;
					end
				end
			end
			default: begin
				state_nx = state;
			end
		endcase
	end

endmodule

[hdl/trc_chk.sv]
// Port-level checker for the TFTP read client, bound to the top level.
`include "tftp_read_client_fsm_defines.svh"

module trc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [trc_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [1:0]  req;
	logic [15:0] ack_blk;
	logic        dlv;
	logic [15:0] plen;
	logic [1:0]  stat;

	assign req     = m_tdata[trc_pkg::O_REQ_LO +: 2];
	assign ack_blk = m_tdata[trc_pkg::O_ACK_LO +: 16];
	assign dlv     = m_tdata[trc_pkg::O_DLV];
	assign plen    = m_tdata[trc_pkg::O_PLEN_LO +: 16];
	assign stat    = m_tdata[trc_pkg::O_STAT_LO +: 2];

	// a stalled result holds
	`TRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// an ack never names block zero: either a fresh block or a resend after one
	`TRC_ASSERT_NOW(a_ack_nonzero, m_tvalid && req == trc_pkg::REQ_ACK, ack_blk != 16'd0)
	// no ack, no block number
	`TRC_ASSERT_NOW(a_ack_only, m_tvalid && req != trc_pkg::REQ_ACK, ack_blk == 16'd0)
	// payload length only with a delivery
	`TRC_ASSERT_NOW(a_plen_only, m_tvalid && !dlv, plen == 16'd0)
	// a stopping event asks for no packet
	`TRC_ASSERT_NOW(a_stop_quiet, m_tvalid && stat != trc_pkg::ST_BUSY,
		req == trc_pkg::REQ_NONE)

endmodule

bind tftp_read_client_fsm trc_chk u_trc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/tftp_read_client_fsm_test.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench of the TFTP read client event machine.
module tftp_read_client_fsm_test;

	localparam int CYCLE_LIMIT = 100_000;
	// no idling on either side inside this window of cycles
	localparam int QUIET_FROM  = 500;
	localparam int QUIET_TO    = 1_100;
	localparam int ITEM_W      = $bits(trc_pkg::item_t);

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	// fields from bit 0: send_ok, source_port, packet_length, packet_opcode,
	// packet_block, sink_ok, zero fill
	logic [trc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	// fields from bit 0: command
	logic [1:0]                     s_tuser   = trc_pkg::CMD_START;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	// fields from bit 0: send_request, ack_block, deliver_payload, payload_length,
	// latch_port, status, zero fill
	logic [trc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [0:0]                     cfg_index = trc_pkg::CFG_MAX_TRIES;
	logic [15:0]                    cfg_wdata = '0;

	// Events waiting to be driven, and the results the client is due to give.
	trc_pkg::item_t   event_queue[$];
	trc_pkg::result_t due_results[$];
	trc_pkg::item_t   cur_event;

	// Shadow of the client: transfer state and registers.
	trc_pkg::phase_t model_phase     = trc_pkg::PH_IDLE;
	logic [15:0]     model_block     = '0;
	logic            model_eof       = 1'b0;
	logic [3:0]      model_tries     = '0;
	logic [15:0]     model_port      = '0;
	logic [3:0]      model_max_tries = trc_pkg::RESET_TRIES;
	logic [15:0]     model_xfer_size = trc_pkg::RESET_XFER;

	int cycles     = 0;
	int queued     = 0;
	int accepted   = 0;
	int results    = 0;
	int delivered  = 0;
	int done_ok    = 0;
	int done_fail  = 0;
	int failures   = 0;
	int settings   = 1;

	tftp_read_client_fsm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Random idling on either side, at a chance of 6 in 100, none in the quiet window.
	function automatic logic take_break();
		if (cycles >= QUIET_FROM && cycles < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 6;
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic rnd1();
		return 1'($urandom_range(1));
	endfunction

	// Drop back to idle and report how the transfer ended.
	function automatic logic [1:0] stop_transfer();
		model_phase = trc_pkg::PH_IDLE;
		return model_eof ? trc_pkg::ST_OK : trc_pkg::ST_FAIL;
	endfunction

	// Apply one event to the shadow client and return the result it must give.
	function automatic trc_pkg::result_t advance_client(input trc_pkg::item_t ev);
		trc_pkg::result_t r;
		logic             take;
		logic [15:0]      paylen;
		r      = '0;
		take   = 1'b0;
		paylen = ev.packet_length - trc_pkg::HDR_LEN;
		case (ev.command)
		trc_pkg::CMD_START: begin
			// a start always restarts from the beginning, busy or not
			model_block       = '0;
			model_eof         = 1'b0;
			model_tries       = '0;
			model_phase       = trc_pkg::PH_SEND;
			r.send_request    = trc_pkg::REQ_RRQ;
		end
		trc_pkg::CMD_SENT: begin
			if (model_phase == trc_pkg::PH_SEND) begin
				if (ev.send_ok && !model_eof) begin
					model_phase = trc_pkg::PH_WAIT;
					if (model_tries != trc_pkg::TRY_MAX)
						model_tries = model_tries + 4'd1;
				end else begin
					r.status = stop_transfer();
				end
			end
		end
		trc_pkg::CMD_PACKET: begin
			if (model_phase == trc_pkg::PH_WAIT) begin
				// the first reply names the server port; later ones must match it
				if (model_block == 16'd0) begin
					model_port   = ev.source_port;
					r.latch_port = 1'b1;
					take         = 1'b1;
				end else begin
					take = (model_port == ev.source_port);
				end
				if (take) begin
					if (ev.packet_length < trc_pkg::HDR_LEN) begin
						// runt packet: ask again, keep the try count
						model_phase    = trc_pkg::PH_SEND;
						r.send_request = trc_pkg::REQ_RRQ;
					end else begin
						model_tries = '0;
						if (ev.packet_opcode != trc_pkg::OP_DATA) begin
							r.status = stop_transfer();
						end else if ({1'b0, model_block} + 17'd1
							== {1'b0, ev.packet_block}) begin
							// the expected block never matches once the counter is full
							model_block       = ev.packet_block;
							r.deliver_payload = 1'b1;
							r.payload_length  = paylen;
							if (paylen < model_xfer_size)
								model_eof = 1'b1;
							if (ev.sink_ok) begin
								model_phase    = trc_pkg::PH_SEND;
								r.send_request = trc_pkg::REQ_ACK;
							end else begin
								r.status = stop_transfer();
							end
						end
					end
				end
			end
		end
		trc_pkg::CMD_TIMEOUT: begin
			if (model_phase == trc_pkg::PH_WAIT) begin
				if (model_tries < model_max_tries) begin
					model_phase    = trc_pkg::PH_SEND;
					r.send_request = (model_block == 16'd0) ? trc_pkg::REQ_RRQ
					                                        : trc_pkg::REQ_ACK;
				end else begin
					r.status = stop_transfer();
				end
			end
		end
		default: begin
			r = '0;
		end
		endcase
		if (r.send_request == trc_pkg::REQ_ACK)
			r.ack_block = model_block;
		return r;
	endfunction

	// Driver: hand the next queued event to the slave side, advance the shadow on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_results.push_back(advance_client(cur_event));
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (event_queue.size() != 0 && !take_break()) begin
					cur_event = event_queue.pop_front();
					s_tdata   <= {6'd0, cur_event.sink_ok, cur_event.packet_block,
						cur_event.packet_opcode, cur_event.packet_length,
						cur_event.source_port, cur_event.send_ok};
					s_tuser   <= cur_event.command;
					s_tvalid  <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Monitor: take each result request and hold it against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		trc_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results++;
				if (due_results.size() == 0) begin
					$error("result with no event outstanding: %h", m_tdata);
					failures++;
				end else begin
					want = due_results.pop_front();
					check_field("send_request", 16'(want.send_request),
						16'(m_tdata[trc_pkg::O_REQ_LO +: 2]));
					check_field("ack_block", want.ack_block,
						m_tdata[trc_pkg::O_ACK_LO +: 16]);
					check_field("deliver_payload", 16'(want.deliver_payload),
						16'(m_tdata[trc_pkg::O_DLV]));
					check_field("payload_length", want.payload_length,
						m_tdata[trc_pkg::O_PLEN_LO +: 16]);
					check_field("latch_port", 16'(want.latch_port),
						16'(m_tdata[trc_pkg::O_LATCH]));
					check_field("status", 16'(want.status),
						16'(m_tdata[trc_pkg::O_STAT_LO +: 2]));
					if (want.deliver_payload)
						delivered++;
					if (want.status == trc_pkg::ST_OK)
						done_ok++;
					else if (want.status == trc_pkg::ST_FAIL)
						done_fail++;
				end
			end
			m_tready <= !take_break();
		end
	end

	task automatic add_event(input trc_pkg::cmd_t cmd, input logic ok, input logic [15:0] port,
		input logic [15:0] len, input logic [15:0] op, input logic [15:0] blk, input logic sink);
		trc_pkg::item_t ev;
		ev.command       = cmd;
		ev.send_ok       = ok;
		ev.source_port   = port;
		ev.packet_length = len;
		ev.packet_opcode = op;
		ev.packet_block  = blk;
		ev.sink_ok       = sink;
		event_queue.push_back(ev);
		queued++;
	endtask

	// Events whose unused fields carry random bits.
	task automatic add_start();
		add_event(trc_pkg::CMD_START, rnd1(), rnd16(), rnd16(), rnd16(), rnd16(), rnd1());
	endtask

	task automatic add_sent(input logic ok);
		add_event(trc_pkg::CMD_SENT, ok, rnd16(), rnd16(), rnd16(), rnd16(), rnd1());
	endtask

	task automatic add_timeout();
		add_event(trc_pkg::CMD_TIMEOUT, rnd1(), rnd16(), rnd16(), rnd16(), rnd16(), rnd1());
	endtask

	// Fully random request, mostly ignored by the client; not counted as stimulus.
	task automatic add_noise();
		trc_pkg::item_t ev;
		ev = trc_pkg::item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
		event_queue.push_back(ev);
	endtask

	// One read transfer of nblk blocks against the current settings, with faults mixed in.
	task automatic add_transfer(input int nblk);
		logic [15:0] port;
		logic [15:0] len;
		logic [15:0] op;
		int          full;
		int          r;
		full = (model_xfer_size == 16'd0) ? 65535 : model_xfer_size + 4;
		if (full > 65535)
			full = 65535;
		port = rnd16();
		add_start();
		add_sent($urandom_range(99) < 97);
		for (int b = 1; b <= nblk; b++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				add_timeout();
				add_sent(1'b1);
			end else if (r < 12) begin
				add_event(trc_pkg::CMD_PACKET, rnd1(), (b == 1) ? rnd16() : port,
					16'($urandom_range(3)), rnd16(), rnd16(), rnd1());
				add_sent(1'b1);
			end else if (r < 16 && b > 1) begin
				add_event(trc_pkg::CMD_PACKET, rnd1(),
					port ^ 16'($urandom_range(1, 16'hFFFF)),
					16'(full), trc_pkg::OP_DATA, 16'(b), 1'b1);
			end else if (r < 20) begin
				add_event(trc_pkg::CMD_PACKET, rnd1(), port, 16'(full), trc_pkg::OP_DATA,
					16'(($urandom_range(1) != 0) ? b - 1 : b + 1 + $urandom_range(100)),
					1'b1);
			end else if (r < 22) begin
				add_sent(rnd1());
			end
			if (b == nblk && model_xfer_size != 16'd0) begin
				len = 16'(4 + $urandom_range(model_xfer_size - 1));
				if (len < trc_pkg::HDR_LEN)
					len = 16'hFFFF;
			end else begin
				len = 16'(full);
			end
			op = ($urandom_range(99) < 2) ? rnd16() : trc_pkg::OP_DATA;
			add_event(trc_pkg::CMD_PACKET, rnd1(), port, len, op, 16'(b),
				$urandom_range(99) < 97);
			add_sent($urandom_range(99) < 97);
		end
	endtask

	// Let the retries run out without any reply.
	task automatic add_give_up();
		add_start();
		add_sent(1'b1);
		repeat (model_max_tries) begin
			add_timeout();
			add_sent(1'b1);
		end
		add_timeout();
	endtask

	// Runt replies keep the try count, so it climbs to its ceiling.
	task automatic add_try_ceiling();
		add_start();
		add_sent(1'b1);
		repeat (18) begin
			add_event(trc_pkg::CMD_PACKET, rnd1(), rnd16(), 16'($urandom_range(3)), rnd16(),
				rnd16(), rnd1());
			add_sent(1'b1);
		end
		add_timeout();
	endtask

	task automatic fill_random(input int target);
		int first;
		int r;
		first = queued;
		while (queued - first < target) begin
			r = $urandom_range(99);
			if (r < 72)
				add_transfer(($urandom_range(9) == 0) ? $urandom_range(7, 20)
				                                      : $urandom_range(1, 6));
			else if (r < 82)
				add_give_up();
			else if (r < 86)
				add_try_ceiling();
			else
				repeat ($urandom_range(1, 4)) add_noise();
		end
	endtask

	// Hold off until the driver is empty and every result has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (event_queue.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == trc_pkg::CFG_MAX_TRIES)
			model_max_tries = value[3:0];
		else
			model_xfer_size = value;
	endtask

	task automatic set_config(input logic [3:0] tries, input logic [15:0] size);
		// upper bits of the try limit are junk and must be dropped
		write_reg(trc_pkg::CFG_MAX_TRIES, {12'($urandom_range(12'hFFF)), tries});
		write_reg(trc_pkg::CFG_XFER_SIZE, size);
		settings++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings.
		add_sent(1'b1);                                               // idle: ignored
		add_event(trc_pkg::CMD_PACKET, 1'b1, 16'd7, 16'd516, trc_pkg::OP_DATA, 16'd1, 1'b1);
		add_timeout();
		add_start();
		add_start();                                                  // restart while busy
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b0, 16'd0, 16'd3, trc_pkg::OP_DATA, 16'd1,
			1'b1);                                                    // runt
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b0, 16'hFFFF, 16'd516, trc_pkg::OP_DATA, 16'd1,
			1'b1);
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b0, 16'd0, 16'd516, trc_pkg::OP_DATA, 16'd2,
			1'b1);                                                    // wrong port
		add_event(trc_pkg::CMD_PACKET, 1'b0, 16'hFFFF, 16'd516, trc_pkg::OP_DATA, 16'hFFFF,
			1'b1);                                                    // out of order
		add_timeout();
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b1, 16'hFFFF, 16'hFFFF, trc_pkg::OP_DATA, 16'd2,
			1'b1);
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b1, 16'hFFFF, 16'd4, trc_pkg::OP_DATA, 16'd3,
			1'b0);                                                    // sink refuses
		add_start();
		add_sent(1'b0);                                               // send fails
		add_start();
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b1, 16'h1234, 16'd0, 16'd0, 16'd0, 1'b0);
		add_sent(1'b1);
		add_event(trc_pkg::CMD_PACKET, 1'b0, 16'h1234, 16'd4, 16'hFFFF, 16'd1,
			1'b1);                                                    // not data
		wait_drained();

		// Random part over several settings, extremes first.
		fill_random(230);
		wait_drained();
		set_config(4'd1, 16'd1);
		fill_random(230);
		wait_drained();
		set_config(4'd15, 16'hFFFF);
		fill_random(230);
		wait_drained();
		set_config(4'd0, 16'd0);
		fill_random(140);
		wait_drained();
		set_config(4'd3, 16'd16);
		fill_random(230);
		wait_drained();
		set_config(4'($urandom_range(1, 15)), 16'($urandom_range(1, 2048)));
		fill_random(230);
		wait_drained();
		set_config(4'($urandom_range(1, 15)), 16'($urandom_range(1, 16'hFFFF)));
		fill_random(180);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Covered %0d events and %0d results over %0d settings, with faults,",
			accepted, results, settings);
		$display("retries and stalls mixed in; %0d payloads delivered, %0d ended well, %0d failed.",
			delivered, done_ok, done_fail);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
